// File: rtl/tfd_pkg.sv
// shared types and constants for the typed frame deframer
package tfd_pkg;

    localparam int unsigned TYPE_SLOTS_DEF = 16;
    localparam int unsigned HDR_BYTES      = 10;
    localparam int unsigned TRAILER_BYTES  = 8;
    localparam int unsigned CFG_ADDR_W     = 5;

    localparam logic [31:0] LEN_LIMIT_RST      = 32'd1048576;
    localparam logic [7:0]  MAGIC_FIRST_RST    = 8'd0;
    localparam logic [7:0]  MAGIC_SECOND_RST   = 8'd0;
    localparam logic [7:0]  WIRE_VERSION_RST   = 8'd1;
    localparam logic [7:0]  CORR_FLAG_MASK_RST = 8'd1;

    typedef enum logic [2:0] {
        REG_LEN_LIMIT      = 3'd0,
        REG_MAGIC_FIRST    = 3'd1,
        REG_MAGIC_SECOND   = 3'd2,
        REG_WIRE_VERSION   = 3'd3,
        REG_CORR_FLAG_MASK = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        EV_PAYLOAD  = 2'd0,
        EV_COMPLETE = 2'd1,
        EV_REJECT   = 2'd2,
        EV_REGISTER = 2'd3
    } event_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_HDR   = 3'd1,
        ST_TOO_LONG  = 3'd2,
        ST_UNKNOWN   = 3'd3,
        ST_SHORT_TRL = 3'd4,
        ST_EXISTS    = 3'd5,
        ST_FULL      = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_EMIT2
    } ctl_state_t;

    // what the sequencer asks the datapath to do
    typedef enum logic [2:0] {
        OP_NONE,
        OP_STREAM,
        OP_REG,
        OP_HDR_END
    } op_t;

    typedef struct packed {
        logic  load_in;     // latch the accepted item
        logic  search_clr;  // restart table search
        logic  search_step; // look at one more table entry
        op_t   op;          // finish the item once search is done
        logic  out_load1;   // place first result in output register
        logic  out_load2;   // place second result in output register
    } tfd_cmd_t;

    typedef struct packed {
        logic mode;         // latched item is a registration
        logic need_search;  // latched byte is header end (or registration)
        logic search_done;
        logic two_results;  // this item yields payload byte plus record
        logic one_result;
        logic out_full;
    } tfd_sts_t;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [7:0]  out_byte;
        logic [15:0] frame_type;
        logic [7:0]  frame_flags;
        logic        corr_seen;
        logic [63:0] corr_word;
        logic [31:0] payload_length;
        logic [2:0]  status;
        logic [63:0] reject_total;
        logic        last_of_run;
    } tfd_res_t;

    typedef struct packed {
        logic        mode;
        logic [7:0]  data_byte;
        logic [15:0] type_id;
    } tfd_item_t;

endpackage

// File: rtl/tfd_if.sv
// valid/ready channel carrying one item
interface tfd_if #(
    parameter int unsigned W = 25
);
    logic         valid;
    logic         ready;
    logic [W-1:0] payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/typed_frame_deframer_unit.sv
// top level of the typed frame deframer
// usage:
// - in_ch carries one item per handshake: mode, data_byte, type_id packed
//   {mode, data_byte, type_id}; mode 0 is a stream byte, mode 1 registers a
//   message type id in the table
// - out_ch carries result items packed as tfd_res_t
// - apb port writes the five configuration registers at 4*index; write
//   only while the block is idle
// - an accepted item is latched in S_IDLE and its result goes into the output
//   register from S_SEARCH once that register is free; the header-end byte
//   and registrations first walk the type table one entry per cycle, up to
//   table_fill entries
// - the controller takes a new item only once the last one is finished; a
//   byte that yields two results also holds input while S_EMIT2 loads the second
// - reset clears parser, counters and table fill; table contents stay
//   undefined and are never read past the fill
// - if the receiver stalls, the finished result waits in the output
//   register and the sequencer holds the next item until it is taken
module typed_frame_deframer_unit #(
    parameter int unsigned TYPE_SLOTS = tfd_pkg::TYPE_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    tfd_if.sink         in_ch,
    tfd_if.source       out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [tfd_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tfd_pkg::*;

    logic [31:0] len_limit_reg;
    logic [7:0]  magic_first_reg;
    logic [7:0]  magic_second_reg;
    logic [7:0]  wire_version_reg;
    logic [7:0]  corr_flag_mask_reg;
    logic [2:0]  ridx;
    logic        wr_en;
    tfd_cmd_t    cmd;
    tfd_sts_t    sts;
    tfd_res_t    res;
    logic        out_valid;
    logic        out_taken;

    assign pready = 1'b1;
    assign ridx = paddr[4:2];
    assign wr_en = psel && penable && pwrite;

    // register file, word-aligned
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_limit_reg <= LEN_LIMIT_RST;
            magic_first_reg <= MAGIC_FIRST_RST;
            magic_second_reg <= MAGIC_SECOND_RST;
            wire_version_reg <= WIRE_VERSION_RST;
            corr_flag_mask_reg <= CORR_FLAG_MASK_RST;
        end
        else if (wr_en)
        begin
            case (ridx)
                REG_LEN_LIMIT:      len_limit_reg <= pwdata;
                REG_MAGIC_FIRST:    magic_first_reg <= pwdata[7:0];
                REG_MAGIC_SECOND:   magic_second_reg <= pwdata[7:0];
                REG_WIRE_VERSION:   wire_version_reg <= pwdata[7:0];
                REG_CORR_FLAG_MASK: corr_flag_mask_reg <= pwdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (ridx)
            REG_LEN_LIMIT:      prdata = len_limit_reg;
            REG_MAGIC_FIRST:    prdata = {24'd0, magic_first_reg};
            REG_MAGIC_SECOND:   prdata = {24'd0, magic_second_reg};
            REG_WIRE_VERSION:   prdata = {24'd0, wire_version_reg};
            REG_CORR_FLAG_MASK: prdata = {24'd0, corr_flag_mask_reg};
            default:            prdata = 32'd0;
        endcase
    end

    assign out_taken = out_valid && out_ch.ready;
    assign out_ch.valid = out_valid;
    assign out_ch.payload = res;

    tfd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_taken (out_taken),
        .sts       (sts),
        .cmd       (cmd)
    );

    tfd_datapath #(
        .TYPE_SLOTS (TYPE_SLOTS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .item           (tfd_item_t'(in_ch.payload)),
        .cmd            (cmd),
        .out_taken      (out_taken),
        .len_limit      (len_limit_reg),
        .magic_first    (magic_first_reg),
        .magic_second   (magic_second_reg),
        .wire_version   (wire_version_reg),
        .corr_flag_mask (corr_flag_mask_reg),
        .sts            (sts),
        .out_valid      (out_valid),
        .res            (res)
    );

    a_ready_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("second item taken while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
        else $error("result dropped under stall");
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");
endmodule

// File: rtl/tfd_ctrl.sv
// control sequencer for the deframer
module tfd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                out_taken,
    input  tfd_pkg::tfd_sts_t   sts,
    output tfd_pkg::tfd_cmd_t   cmd
);
    import tfd_pkg::*;

    ctl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.op = OP_NONE;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    cmd.search_clr = 1'b1;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (sts.need_search && !sts.search_done)
                begin
                    cmd.search_step = 1'b1;
                end
                else if (!sts.out_full || out_taken)
                begin
                    cmd.op = sts.mode ? OP_REG : (sts.need_search ? OP_HDR_END : OP_STREAM);
                    if (sts.one_result || sts.two_results)
                    begin
                        cmd.out_load1 = 1'b1;
                    end
                    state_next = sts.two_results ? S_EMIT2 : S_IDLE;
                end
            end
            S_EMIT2:
            begin
                if (!sts.out_full || out_taken)
                begin
                    cmd.out_load2 = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.out_load1 && cmd.out_load2))
        else $error("two result loads at once");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load1 || cmd.out_load2) |-> (!sts.out_full || out_taken))
        else $error("result register overwritten");
    a_emit2_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT2) |-> $past(state_reg == S_SEARCH || state_reg == S_EMIT2))
        else $error("second result out of order");
endmodule

// File: rtl/tfd_datapath.sv
// parser registers, type table and result register
module tfd_datapath #(
    parameter int unsigned TYPE_SLOTS = tfd_pkg::TYPE_SLOTS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tfd_pkg::tfd_item_t    item,
    input  tfd_pkg::tfd_cmd_t     cmd,
    input  logic                  out_taken,
    input  logic [31:0]           len_limit,
    input  logic [7:0]            magic_first,
    input  logic [7:0]            magic_second,
    input  logic [7:0]            wire_version,
    input  logic [7:0]            corr_flag_mask,
    output tfd_pkg::tfd_sts_t     sts,
    output logic                  out_valid,
    output tfd_pkg::tfd_res_t     res
);
    import tfd_pkg::*;

    localparam int unsigned IW = (TYPE_SLOTS > 1) ? $clog2(TYPE_SLOTS) : 1;
    localparam int unsigned FW = $clog2(TYPE_SLOTS + 1);
    localparam logic [FW-1:0] SLOTS_F = FW'(TYPE_SLOTS);

    tfd_item_t   it_reg;
    logic        hdr_phase_reg;
    logic [3:0]  hidx_reg;
    logic [31:0] bidx_reg;
    logic [7:0]  flags_reg;
    logic [15:0] type_reg;
    logic [31:0] wlen_reg;
    logic [63:0] corr_reg;
    logic [63:0] rej_reg;
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] sidx_reg;
    logic        found_reg;
    logic [15:0] table_reg [TYPE_SLOTS];
    tfd_res_t    res_reg;
    logic        ov_reg;
    tfd_res_t    pend_reg;

    logic [15:0] key;
    logic        corr_on;
    logic [31:0] plen;
    logic [31:0] hdr_len;
    logic        hdr_end_res;
    logic        hdr_res;
    logic        body_res;

    // table is scanned one entry per cycle against the latched key
    assign key = it_reg.mode ? it_reg.type_id : type_reg;
    assign corr_on = |(flags_reg & corr_flag_mask);
    assign plen = corr_on ? wlen_reg - 32'(TRAILER_BYTES) : wlen_reg;
    assign hdr_len = {wlen_reg[23:0], it_reg.data_byte};

    // header end answers only on a reject or an empty body
    assign hdr_end_res = (hdr_len > len_limit) || !found_reg ||
        (corr_on && hdr_len < 32'(TRAILER_BYTES)) || (hdr_len == 32'd0);
    assign hdr_res = (hidx_reg == 4'd0 && it_reg.data_byte != magic_first) ||
        (hidx_reg == 4'd1 && it_reg.data_byte != magic_second) ||
        (hidx_reg == 4'd2 && it_reg.data_byte != wire_version) ||
        (hidx_reg == 4'd9 && hdr_end_res);
    // trailer bytes before the last one answer nothing
    assign body_res = (bidx_reg < plen) || (bidx_reg >= wlen_reg - 32'd1);

    assign sts.mode = it_reg.mode;
    assign sts.need_search = it_reg.mode || (hdr_phase_reg && hidx_reg == 4'd9);
    assign sts.search_done = found_reg || (sidx_reg >= fill_reg);
    assign sts.out_full = ov_reg;
    assign sts.two_results = !it_reg.mode && !hdr_phase_reg && (bidx_reg < plen)
        && (bidx_reg >= wlen_reg - 32'd1);
    assign sts.one_result = !sts.two_results &&
        (it_reg.mode || (hdr_phase_reg ? hdr_res : body_res));

    assign out_valid = ov_reg;
    assign res = res_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            it_reg <= item;
        end
        if (cmd.op == OP_REG && !found_reg && fill_reg < SLOTS_F)
        begin
            table_reg[IW'(fill_reg)] <= it_reg.type_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_phase_reg <= 1'b1;
            hidx_reg <= '0;
            bidx_reg <= '0;
            flags_reg <= '0;
            type_reg <= '0;
            wlen_reg <= '0;
            corr_reg <= '0;
            rej_reg <= '0;
            fill_reg <= '0;
            sidx_reg <= '0;
            found_reg <= 1'b0;
            ov_reg <= 1'b0;
            res_reg <= '0;
            pend_reg <= '0;
        end
        else
        begin
            tfd_res_t r;
            logic [63:0] rej_n;
            r = '0;
            rej_n = rej_reg;
            if (out_taken)
            begin
                ov_reg <= 1'b0;
            end
            if (cmd.search_clr)
            begin
                sidx_reg <= '0;
                found_reg <= 1'b0;
            end
            if (cmd.search_step)
            begin
                if (table_reg[IW'(sidx_reg)] == key)
                begin
                    found_reg <= 1'b1;
                end
                else
                begin
                    sidx_reg <= sidx_reg + FW'(1);
                end
            end
            r.last_of_run = 1'b1;
            case (cmd.op)
                OP_REG:
                begin
                    r.event_res = EV_REGISTER;
                    r.frame_type = it_reg.type_id;
                    if (found_reg)
                    begin
                        r.status = ST_EXISTS;
                    end
                    else if (fill_reg >= SLOTS_F)
                    begin
                        r.status = ST_FULL;
                    end
                    else
                    begin
                        r.status = ST_OK;
                        fill_reg <= fill_reg + FW'(1);
                    end
                end
                OP_HDR_END:
                begin
                    r.frame_type = type_reg;
                    r.frame_flags = flags_reg;
                    hidx_reg <= '0;
                    if (hdr_len > len_limit || !found_reg ||
                        (corr_on && hdr_len < 32'(TRAILER_BYTES)))
                    begin
                        r.event_res = EV_REJECT;
                        r.status = (hdr_len > len_limit) ? ST_TOO_LONG :
                            (!found_reg ? ST_UNKNOWN : ST_SHORT_TRL);
                        rej_n = rej_reg + 64'd1;
                    end
                    else if (hdr_len == 32'd0)
                    begin
                        r.event_res = EV_COMPLETE;
                        r.corr_seen = corr_on;
                    end
                    else
                    begin
                        hdr_phase_reg <= 1'b0;
                        bidx_reg <= '0;
                    end
                    wlen_reg <= hdr_len;
                end
                OP_STREAM:
                begin
                    r.frame_type = type_reg;
                    r.frame_flags = flags_reg;
                    if (hdr_phase_reg)
                    begin
                        hidx_reg <= hidx_reg + 4'd1;
                        case (hidx_reg)
                            4'd0:
                            begin
                                flags_reg <= '0;
                                type_reg <= '0;
                                wlen_reg <= '0;
                                corr_reg <= '0;
                                r.frame_type = '0;
                                r.frame_flags = '0;
                                if (it_reg.data_byte != magic_first)
                                begin
                                    r.event_res = EV_REJECT;
                                    r.status = ST_BAD_HDR;
                                    rej_n = rej_reg + 64'd1;
                                    hidx_reg <= '0;
                                end
                            end
                            4'd1, 4'd2:
                            begin
                                if (it_reg.data_byte != ((hidx_reg == 4'd1) ?
                                    magic_second : wire_version))
                                begin
                                    r.event_res = EV_REJECT;
                                    r.status = ST_BAD_HDR;
                                    rej_n = rej_reg + 64'd1;
                                    hidx_reg <= '0;
                                end
                            end
                            4'd3: flags_reg <= it_reg.data_byte;
                            4'd4, 4'd5: type_reg <= {type_reg[7:0], it_reg.data_byte};
                            default: wlen_reg <= {wlen_reg[23:0], it_reg.data_byte};
                        endcase
                    end
                    else
                    begin
                        logic [63:0] c_n;
                        c_n = corr_reg;
                        if (bidx_reg < plen)
                        begin
                            r.event_res = EV_PAYLOAD;
                            r.out_byte = it_reg.data_byte;
                        end
                        else
                        begin
                            c_n = {corr_reg[55:0], it_reg.data_byte};
                            corr_reg <= c_n;
                        end
                        if (bidx_reg >= wlen_reg - 32'd1)
                        begin
                            tfd_res_t c;
                            c = '0;
                            c.event_res = EV_COMPLETE;
                            c.frame_type = type_reg;
                            c.frame_flags = flags_reg;
                            c.corr_seen = corr_on;
                            c.corr_word = corr_on ? c_n : 64'd0;
                            c.payload_length = plen;
                            c.reject_total = rej_reg;
                            c.last_of_run = 1'b1;
                            if (bidx_reg < plen)
                            begin
                                r.last_of_run = 1'b0;
                                pend_reg <= c;
                            end
                            else
                            begin
                                r = c;
                            end
                            hdr_phase_reg <= 1'b1;
                            hidx_reg <= '0;
                        end
                        else
                        begin
                            bidx_reg <= bidx_reg + 32'd1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            r.reject_total = rej_n;
            rej_reg <= rej_n;
            if (cmd.out_load1)
            begin
                res_reg <= r;
                ov_reg <= 1'b1;
            end
            if (cmd.out_load2)
            begin
                res_reg <= pend_reg;
                ov_reg <= 1'b1;
            end
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= SLOTS_F)
        else $error("type table overfilled");
    a_rej_step: assert property (@(posedge clk) disable iff (!rst_n)
        (rej_reg != $past(rej_reg)) |-> (rej_reg == $past(rej_reg) + 64'd1))
        else $error("reject count jumped");
    a_hidx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hidx_reg <= 4'd9)
        else $error("header index overran");
endmodule

// File: dv/tb_top.sv
// self-checking testbench for the typed frame deframer unit
module tb_top;
    import tfd_pkg::*;

    localparam int unsigned IW = $bits(tfd_item_t);
    localparam int unsigned RW = $bits(tfd_res_t);
    localparam int unsigned SLOTS = TYPE_SLOTS_DEF;

    // frame parser mirror: predicts every result item from accepted items
    class frame_scoreboard;
        logic [31:0] max_len;
        logic [7:0]  magic0;
        logic [7:0]  magic1;
        logic [7:0]  version;
        logic [7:0]  corr_mask;

        bit          in_body;
        logic [31:0] byte_idx;
        logic [7:0]  hflags;
        logic [15:0] htype;
        logic [31:0] wlen;
        logic [63:0] corr_acc;
        logic [63:0] rej_cnt;
        logic [15:0] ids[SLOTS];
        int unsigned fill;

        tfd_res_t    expected_q[$];
        int unsigned errors;

        function new();
            max_len   = LEN_LIMIT_RST;
            magic0    = MAGIC_FIRST_RST;
            magic1    = MAGIC_SECOND_RST;
            version   = WIRE_VERSION_RST;
            corr_mask = CORR_FLAG_MASK_RST;
            in_body   = 0;
            byte_idx  = '0;
            hflags    = '0;
            htype     = '0;
            wlen      = '0;
            corr_acc  = '0;
            rej_cnt   = '0;
            fill      = 0;
            errors    = 0;
        endfunction

        function void set_reg(reg_idx_t r, logic [31:0] v);
            case (r)
                REG_LEN_LIMIT:      max_len = v;
                REG_MAGIC_FIRST:    magic0 = v[7:0];
                REG_MAGIC_SECOND:   magic1 = v[7:0];
                REG_WIRE_VERSION:   version = v[7:0];
                REG_CORR_FLAG_MASK: corr_mask = v[7:0];
                default: ;
            endcase
        endfunction

        function bit known(logic [15:0] id);
            for (int i = 0; i < fill; i++)
                if (ids[i] == id)
                    return 1;
            return 0;
        endfunction

        function bit corr_on();
            return (hflags & corr_mask) != 0;
        endfunction

        function bit hdr_start();
            return !in_body && (byte_idx == 0 || byte_idx >= HDR_BYTES);
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function tfd_res_t mk(event_t ev, logic [7:0] b, logic [15:0] ty, logic [7:0] fl,
                              logic hc, logic [63:0] cid, logic [31:0] plen, status_t st);
            tfd_res_t r;
            r.event_res       = ev;
            r.out_byte        = b;
            r.frame_type      = ty;
            r.frame_flags     = fl;
            r.corr_seen       = hc;
            r.corr_word       = cid;
            r.payload_length  = plen;
            r.status          = st;
            r.reject_total    = rej_cnt;
            r.last_of_run     = 1'b0;
            return r;
        endfunction

        function void push(tfd_res_t r, bit last);
            r.last_of_run = last;
            expected_q.push_back(r);
        endfunction

        function void drop_frame(status_t st);
            rej_cnt++;
            in_body  = 0;
            byte_idx = '0;
            push(mk(EV_REJECT, 8'd0, htype, hflags, 1'b0, 64'd0, 32'd0, st), 1);
        endfunction

        function void finish_frame();
            bit c;
            c = corr_on();
            push(mk(EV_COMPLETE, 8'd0, htype, hflags, c, c ? corr_acc : 64'd0,
                    c ? wlen - TRAILER_BYTES : wlen, ST_OK), 1);
            in_body  = 0;
            byte_idx = '0;
        endfunction

        // one accepted input item
        function void note_item(tfd_item_t it);
            logic [31:0] idx;
            logic [31:0] plen;
            logic [7:0]  b;
            status_t     st;
            tfd_res_t    pay;
            bit          have_pay;
            b   = it.data_byte;
            idx = byte_idx;
            if (it.mode) begin
                if (known(it.type_id))
                    st = ST_EXISTS;
                else if (fill >= SLOTS)
                    st = ST_FULL;
                else begin
                    ids[fill] = it.type_id;
                    fill++;
                    st = ST_OK;
                end
                push(mk(EV_REGISTER, 8'd0, it.type_id, 8'd0, 1'b0, 64'd0, 32'd0, st), 1);
                return;
            end
            if (!in_body) begin
                if (idx >= HDR_BYTES)
                    idx = 0;
                if (idx == 0) begin
                    hflags   = '0;
                    htype    = '0;
                    wlen     = '0;
                    corr_acc = '0;
                end
                case (idx)
                    0: if (b != magic0) begin drop_frame(ST_BAD_HDR); return; end
                    1: if (b != magic1) begin drop_frame(ST_BAD_HDR); return; end
                    2: if (b != version) begin drop_frame(ST_BAD_HDR); return; end
                    3: hflags = b;
                    4, 5: htype = {htype[7:0], b};
                    default: wlen = {wlen[23:0], b};
                endcase
                if (idx < HDR_BYTES - 1) begin
                    byte_idx = idx + 1;
                    return;
                end
                // header end checks in fixed priority
                if (wlen > max_len) begin drop_frame(ST_TOO_LONG); return; end
                if (!known(htype)) begin drop_frame(ST_UNKNOWN); return; end
                if (corr_on() && wlen < TRAILER_BYTES) begin
                    drop_frame(ST_SHORT_TRL);
                    return;
                end
                if (wlen == 0) begin
                    finish_frame();
                    return;
                end
                in_body  = 1;
                byte_idx = '0;
                return;
            end
            plen     = corr_on() ? wlen - TRAILER_BYTES : wlen;
            have_pay = 0;
            if (idx < plen) begin
                pay      = mk(EV_PAYLOAD, b, htype, hflags, 1'b0, 64'd0, 32'd0, ST_OK);
                have_pay = 1;
            end else
                corr_acc = {corr_acc[55:0], b};
            if (idx >= wlen - 1) begin
                if (have_pay)
                    push(pay, 0);
                finish_frame();
            end else begin
                byte_idx = idx + 1;
                if (have_pay)
                    push(pay, 1);
            end
        endfunction

        function void flag(string fld, logic [63:0] e, logic [63:0] g);
            errors++;
            if (errors <= 10)
                $display("mismatch on %s: expected %0h got %0h", fld, e, g);
        endfunction

        // one accepted result item
        function void check_result(tfd_res_t got);
            tfd_res_t e;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("result with nothing pending: %p", got);
                return;
            end
            e = expected_q.pop_front();
            if (got.event_res !== e.event_res) flag("event_res", e.event_res, got.event_res);
            if (got.out_byte !== e.out_byte) flag("out_byte", e.out_byte, got.out_byte);
            if (got.frame_type !== e.frame_type) flag("frame_type", e.frame_type, got.frame_type);
            if (got.frame_flags !== e.frame_flags)
                flag("frame_flags", e.frame_flags, got.frame_flags);
            if (got.corr_seen !== e.corr_seen)
                flag("corr_seen", e.corr_seen, got.corr_seen);
            if (got.corr_word !== e.corr_word)
                flag("corr_word", e.corr_word, got.corr_word);
            if (got.payload_length !== e.payload_length)
                flag("payload_length", e.payload_length, got.payload_length);
            if (got.status !== e.status) flag("status", e.status, got.status);
            if (got.reject_total !== e.reject_total)
                flag("reject_total", e.reject_total, got.reject_total);
            if (got.last_of_run !== e.last_of_run)
                flag("last_of_run", e.last_of_run, got.last_of_run);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tfd_if #(.W(IW)) in_ch ();
    tfd_if #(.W(RW)) out_ch ();

    typed_frame_deframer_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    frame_scoreboard sb = new();

    int unsigned items_taken;   // accepted input items so far
    int unsigned items_sent;
    int unsigned gap_pct;       // chance of a gap before an input item
    int unsigned stall_pct;     // chance of a receiver stall
    int unsigned stall_left;
    bit          drained;       // the full drain pause has been done

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // gap lengths: mostly short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(1, 2);
        if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // both monitors sample at the rising edge, before the block's own updates land
    always @(posedge clk) begin
        if (rst_n && in_ch.valid && in_ch.ready) begin
            sb.note_item(tfd_item_t'(in_ch.payload));
            items_taken++;
        end
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(tfd_res_t'(out_ch.payload));
    end

    // receiver: random stalls, changed on the falling edge
    always @(negedge clk) begin
        if (stall_left > 0) begin
            out_ch.ready = 1'b0;
            stall_left--;
        end else begin
            out_ch.ready = 1'b1;
            if ($urandom_range(99) < stall_pct)
                stall_left = pick_gap();
        end
    end

    // offer one item; returns on the falling edge after it was taken
    task automatic put_item(tfd_item_t it);
        int unsigned seen;
        if ($urandom_range(99) < gap_pct) begin
            in_ch.valid = 1'b0;
            repeat (pick_gap()) @(negedge clk);
        end
        in_ch.valid   = 1'b1;
        in_ch.payload = it;
        seen = items_taken;
        while (items_taken == seen)
            @(negedge clk);
        in_ch.valid = 1'b0;
        items_sent++;
    endtask

    task automatic put_byte(logic [7:0] b);
        tfd_item_t it;
        it.mode      = 1'b0;
        it.data_byte = b;
        it.type_id   = 16'($urandom);   // ignored for stream bytes
        put_item(it);
    endtask

    task automatic put_register(logic [15:0] id);
        tfd_item_t it;
        it.mode      = 1'b1;
        it.data_byte = 8'($urandom);    // ignored for registrations
        it.type_id   = id;
        put_item(it);
    endtask

    // header, then body only if the parser took the header;
    // bad_pos < 3 corrupts that magic/version byte and stops there
    task automatic put_frame(logic [15:0] ty, logic [7:0] fl, logic [31:0] len,
                             int bad_pos);
        logic [7:0] hdr[10];
        hdr = '{sb.magic0, sb.magic1, sb.version, fl, ty[15:8], ty[7:0],
                len[31:24], len[23:16], len[15:8], len[7:0]};
        for (int i = 0; i < HDR_BYTES; i++) begin
            if (i == bad_pos) begin
                put_byte(hdr[i] ^ 8'($urandom_range(1, 255)));
                return;
            end
            put_byte(hdr[i]);
        end
        while (sb.in_body) begin
            if ($urandom_range(99) < 4)
                put_register(16'($urandom));   // registration inside a frame
            else
                put_byte(8'($urandom));
        end
    endtask

    task automatic wait_idle();
        while (sb.pending() > 0)
            @(negedge clk);
        // header bytes give no result; let a table walk finish
        repeat (2 * SLOTS + 10) @(negedge clk);
    endtask

    task automatic apb_write(reg_idx_t r, logic [31:0] v);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = CFG_ADDR_W'({r, 2'b00});
        pwdata  = v;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        sb.set_reg(r, v);
    endtask

    function automatic logic [15:0] any_known();
        if (sb.fill == 0)
            return 16'd0;
        return sb.ids[$urandom_range(sb.fill - 1)];
    endfunction

    function automatic logic [15:0] any_unknown();
        logic [15:0] id;
        id = 16'($urandom);
        while (sb.known(id))
            id = 16'($urandom);
        return id;
    endfunction

    // one random step of the stream: a registration, a stray byte or a frame
    task automatic random_step();
        int unsigned r;
        logic [7:0]  fl;
        logic [31:0] len;
        r  = $urandom_range(99);
        fl = 8'($urandom);
        if (r < 8 || sb.fill == 0) begin
            if ($urandom_range(3) == 0)
                put_register(any_known());
            else
                put_register(16'($urandom));
        end else if (r < 18) begin
            // stray byte that fails magic at once, so the parser stays aligned
            if (sb.hdr_start())
                put_byte(sb.magic0 ^ 8'($urandom_range(1, 255)));
        end else if (r < 28) begin
            put_frame(any_known(), fl, 32'($urandom_range(12)), $urandom_range(2));
        end else if (r < 36) begin
            if (sb.max_len == 32'hFFFF_FFFF)
                len = 32'($urandom_range(12));
            else if ($urandom_range(4) == 0 || sb.max_len > 32'hFFFF_FFF0)
                len = 32'hFFFF_FFFF;
            else
                len = sb.max_len + 32'($urandom_range(1, 4));
            put_frame(any_known(), fl, len, 99);
        end else if (r < 43) begin
            put_frame(any_unknown(), fl, 32'($urandom_range(12)), 99);
        end else if (r < 50) begin
            put_frame(any_known(), fl | sb.corr_mask, 32'($urandom_range(7)), 99);
        end else begin
            if ((fl & sb.corr_mask) != 0)
                len = 32'($urandom_range(8, 16));
            else
                len = 32'($urandom_range(12));
            put_frame(any_known(), fl, len, 99);
        end
    endtask

    initial begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        out_ch.ready  = 1'b0;
        items_taken   = 0;
        items_sent    = 0;
        gap_pct       = 20;
        stall_pct     = 20;
        stall_left    = 0;
        drained       = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: table edges, each reject reason, empty body, trailer frame
        put_register(16'h0000);
        put_register(16'hFFFF);
        put_register(16'h0000);                    // duplicate id
        put_register(16'h1234);
        put_frame(16'h1234, 8'h00, 32'd0, 99);     // empty body completes at header end
        put_frame(16'hFFFF, 8'h01, 32'd9, 99);     // one payload byte plus trailer
        put_frame(16'h0000, 8'h01, 32'd3, 99);     // trailer flag with short length
        put_frame(16'h4321, 8'hFE, 32'd2, 99);     // type not registered
        put_frame(16'h1234, 8'h00, 32'hFFFF_FFFF, 99);
        put_frame(16'h1234, 8'h00, 32'd4, 1);      // second magic byte wrong

        for (int ph = 0; ph < 5; ph++) begin
            if (ph > 0) begin
                wait_idle();
                case (ph)
                    1: begin
                        apb_write(REG_LEN_LIMIT, 32'd40);
                        apb_write(REG_MAGIC_FIRST, 32'($urandom_range(255)));
                        apb_write(REG_MAGIC_SECOND, 32'($urandom_range(255)));
                        apb_write(REG_WIRE_VERSION, 32'($urandom_range(255)));
                        apb_write(REG_CORR_FLAG_MASK, 32'hFF);
                    end
                    2: begin
                        apb_write(REG_LEN_LIMIT, 32'hFFFF_FFFF);
                        apb_write(REG_MAGIC_FIRST, 32'hFF);
                        apb_write(REG_MAGIC_SECOND, 32'hFF);
                        apb_write(REG_WIRE_VERSION, 32'hFF);
                        apb_write(REG_CORR_FLAG_MASK, 32'h00);
                    end
                    3: begin
                        apb_write(REG_LEN_LIMIT, 32'd0);
                        apb_write(REG_MAGIC_FIRST, 32'h00);
                        apb_write(REG_MAGIC_SECOND, 32'h5A);
                        apb_write(REG_WIRE_VERSION, 32'h00);
                        apb_write(REG_CORR_FLAG_MASK, 32'h80);
                    end
                    default: begin
                        apb_write(REG_LEN_LIMIT, 32'd12);
                        apb_write(REG_MAGIC_FIRST, 32'($urandom_range(255)));
                        apb_write(REG_MAGIC_SECOND, 32'($urandom_range(255)));
                        apb_write(REG_WIRE_VERSION, 32'($urandom_range(255)));
                        apb_write(REG_CORR_FLAG_MASK, 32'($urandom_range(255)));
                    end
                endcase
            end
            for (int n = 0; n < 360; ) begin
                // change idling pattern every so often, with stretches of none
                if (n % 90 == 0) begin
                    gap_pct   = ($urandom_range(2) == 0) ? 0 : $urandom_range(5, 40);
                    stall_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(5, 40);
                end
                if (ph == 2 && !drained && n >= 150) begin
                    // hold the stream until the block has delivered everything
                    while (sb.pending() > 0)
                        @(negedge clk);
                    drained = 1'b1;
                end
                n -= items_sent;
                random_step();
                n += items_sent;
            end
        end

        in_ch.valid = 1'b0;
        while (sb.pending() > 0)
            @(negedge clk);
        repeat (2 * SLOTS + 10) @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog
    initial begin
        #4000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
